// ----- hdl/mfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_pkg: shared definitions for the meter frame receiver
// Frame constants, byte role and frame status codes, configuration register
// indexes and the result record passed between the parser and output stage.
// ----------------------------------------------------------------------------
package mfr_pkg;

	// Frame constants
	localparam logic [7:0] START_BYTE   = 8'h68;
	localparam logic [7:0] END_BYTE     = 8'h16;
	localparam logic [7:0] DATA_OFFSET  = 8'h33;
	localparam logic [3:0] HEADER_BYTES = 4'd10;

	// Byte roles
	localparam logic [3:0] ROLE_DROPPED  = 4'd0;
	localparam logic [3:0] ROLE_START    = 4'd1;
	localparam logic [3:0] ROLE_ADDRESS  = 4'd2;
	localparam logic [3:0] ROLE_START2   = 4'd3;
	localparam logic [3:0] ROLE_CONTROL  = 4'd4;
	localparam logic [3:0] ROLE_LENGTH   = 4'd5;
	localparam logic [3:0] ROLE_DATA     = 4'd6;
	localparam logic [3:0] ROLE_CHECKSUM = 4'd7;
	localparam logic [3:0] ROLE_END      = 4'd8;

	// Frame status
	localparam logic [1:0] STATUS_NONE       = 2'd0;
	localparam logic [1:0] STATUS_GOOD       = 2'd1;
	localparam logic [1:0] STATUS_HDR_REJECT = 2'd2;
	localparam logic [1:0] STATUS_BAD_TAIL   = 2'd3;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DATA_LEN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REQ_DIR      = 1'd1;
	localparam logic [7:0] MAX_DATA_LEN_RST = 8'd200;
	localparam logic       REQ_DIR_RST      = 1'b1;

	typedef struct packed {
		logic [7:0] max_data_len;
		logic       required_direction;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] byte_role;
		logic       frame_done;
		logic [1:0] frame_status;
		logic [7:0] data_length;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/mfr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_if: valid/ready channels of the meter frame receiver
// mfr_byte_if carries raw link bytes in, mfr_result_if carries tagged bytes out.
// ----------------------------------------------------------------------------
interface mfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       block_last;

	modport source (output valid, output rx_byte, output block_last, input ready);
	modport sink   (input valid, input rx_byte, input block_last, output ready);
endinterface

interface mfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic [3:0] byte_role;
	logic       frame_done;
	logic [1:0] frame_status;
	logic [7:0] data_length;

	modport source (output valid, output byte_value, output byte_role, output frame_done,
		output frame_status, output data_length, input ready);
	modport sink   (input valid, input byte_value, input byte_role, input frame_done,
		input frame_status, input data_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/mfr_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_parser: frame state tracker
// Classifies each accepted byte against the frame layout, keeps the running
// checksum and header checks, and produces the result record for that byte.
// ----------------------------------------------------------------------------
module mfr_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            block_last,
	input  wire mfr_pkg::cfg_t   cfg,
	output mfr_pkg::result_t     result
);
	import mfr_pkg::*;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [3:0] pos_q, pos_d;
	logic [8:0] rem_q, rem_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] len_q, len_d;
	logic       start2_ok_q, start2_ok_d;
	logic       dir_ok_q, dir_ok_d;
	logic [7:0] cks_q, cks_d;
	logic [8:0] rem_dec;
	logic       hdr_ok;

	assign rem_dec = rem_q - 9'd1;
	assign hdr_ok  = start2_ok_q && dir_ok_q && (len_q <= cfg.max_data_len);

	// Decode the byte against the current phase
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		rem_d       = rem_q;
		sum_d       = sum_q;
		len_d       = len_q;
		start2_ok_d = start2_ok_q;
		dir_ok_d    = dir_ok_q;
		cks_d       = cks_q;

		result.byte_value   = rx_byte;
		result.byte_role    = ROLE_DROPPED;
		result.frame_done   = 1'b0;
		result.frame_status = STATUS_NONE;
		result.data_length  = 8'd0;

		case (phase_q)
			PH_HEAD: begin
				pos_d = pos_q + 4'd1;
				if (pos_q < HEADER_BYTES) begin
					sum_d = sum_q + rx_byte;
					if (pos_q <= 4'd6) begin
						result.byte_role = ROLE_ADDRESS;
					end else if (pos_q == 4'd7) begin
						result.byte_role = ROLE_START2;
						start2_ok_d      = (rx_byte == START_BYTE);
					end else if (pos_q == 4'd8) begin
						result.byte_role = ROLE_CONTROL;
						dir_ok_d         = (rx_byte[7] == cfg.required_direction);
					end else begin
						result.byte_role   = ROLE_LENGTH;
						len_d              = rx_byte;
						result.data_length = rx_byte;
					end
				end else begin
					// First byte after the header: check the header, then enter the body or go back to hunting
					result.data_length = len_q;
					if (!hdr_ok) begin
						result.frame_done   = 1'b1;
						result.frame_status = STATUS_HDR_REJECT;
						phase_d             = PH_HUNT;
					end else begin
						if (len_q == 8'd0) begin
							result.byte_role = ROLE_CHECKSUM;
							cks_d            = rx_byte;
						end else begin
							result.byte_role  = ROLE_DATA;
							result.byte_value = rx_byte - DATA_OFFSET;
							sum_d             = sum_q + rx_byte;
						end
						rem_d   = {1'b0, len_q} + 9'd1;
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				result.data_length = len_q;
				if (rem_q <= 9'd1) begin
					result.byte_role    = ROLE_END;
					result.frame_done   = 1'b1;
					result.frame_status = (rx_byte == END_BYTE && cks_q == sum_q) ?
						STATUS_GOOD : STATUS_BAD_TAIL;
					rem_d               = 9'd0;
					phase_d             = PH_HUNT;
				end else begin
					rem_d = rem_dec;
					if (rem_dec == 9'd1) begin
						result.byte_role = ROLE_CHECKSUM;
						cks_d            = rx_byte;
					end else begin
						result.byte_role  = ROLE_DATA;
						result.byte_value = rx_byte - DATA_OFFSET;
						sum_d             = sum_q + rx_byte;
					end
				end
			end
			default: begin
				// Hunt: drop everything but a start byte
				phase_d = PH_HUNT;
				if (rx_byte == START_BYTE) begin
					result.byte_role = ROLE_START;
					sum_d            = START_BYTE;
					pos_d            = 4'd1;
					rem_d            = 9'd0;
					len_d            = 8'd0;
					start2_ok_d      = 1'b0;
					dir_ok_d         = 1'b0;
					cks_d            = 8'd0;
					phase_d          = PH_HEAD;
				end
			end
		endcase

		// End of block forces a return to hunting
		if (block_last) begin
			phase_d = PH_HUNT;
		end
	end

	// Advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			pos_q       <= 4'd0;
			rem_q       <= 9'd0;
			sum_q       <= 8'd0;
			len_q       <= 8'd0;
			start2_ok_q <= 1'b0;
			dir_ok_q    <= 1'b0;
			cks_q       <= 8'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			rem_q       <= rem_d;
			sum_q       <= sum_d;
			len_q       <= len_d;
			start2_ok_q <= start2_ok_d;
			dir_ok_q    <= dir_ok_d;
			cks_q       <= cks_d;
		end
	end

	// Checks
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.frame_done == (result.frame_status != STATUS_NONE))
		else $error("frame_done and frame_status disagree");

	a_head_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEAD |-> (pos_q >= 4'd1 && pos_q <= HEADER_BYTES))
		else $error("header position out of range");

	a_body_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (rem_q != 9'd0 && rem_q <= {1'b0, len_q} + 9'd1))
		else $error("body byte count out of range");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && block_last) |=> phase_q == PH_HUNT)
		else $error("block end did not return to hunting");

endmodule
`default_nettype wire

// ----- hdl/mfr_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_out_stage: result register
// Holds one result until the downstream side takes it; a new result may be
// loaded in the same cycle that the held one is taken.
// ----------------------------------------------------------------------------
module mfr_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire mfr_pkg::result_t result_d,
	output logic                  can_load,
	output logic                  valid,
	input  wire logic             ready,
	output mfr_pkg::result_t      result_q
);
	import mfr_pkg::*;

	logic valid_q;

	assign can_load = !valid_q || ready;
	assign valid    = valid_q;

	// Hold valid until the transfer, reload on each new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/meter_frame_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// meter_frame_receiver: byte-serial meter link frame receiver
// Tags each raw link byte with its role in the frame and reports frame result.
// ----------------------------------------------------------------------------
// Usage:
//   link   - raw bytes in (rx_byte, block_last) on a valid/ready channel.
//   parsed - one result per byte: value (data bytes less 0x33), role,
//            frame_done/frame_status on the last or rejecting byte, and the
//            frame length field.
//   cfg_*  - write port for max_data_len (index 0) and required_direction
//            (index 1); write only while no byte is in flight.
//   The result of a link transfer is in the output register in the next
//   cycle. One byte is taken every cycle while parsed is not stalled: the
//   frame state update is a single pass of logic and the output register
//   frees itself in the cycle its result is transferred.
//   When parsed is stalled with a result held, link.ready drops and the
//   incoming byte waits upstream; nothing is lost.
//   Reset empties the output register, returns the parser to hunting for a
//   start byte and sets max_data_len to 200, required_direction to 1.
// ----------------------------------------------------------------------------
module meter_frame_receiver (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	mfr_byte_if.sink                             link,
	mfr_result_if.source                         parsed,
	input  wire logic                            cfg_wr_en,
	input  wire logic [mfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mfr_pkg::*;

	cfg_t    cfg_q;
	result_t result_d;
	result_t result_q;
	logic    can_load;
	logic    accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_data_len       <= MAX_DATA_LEN_RST;
			cfg_q.required_direction <= REQ_DIR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MAX_DATA_LEN: cfg_q.max_data_len       <= cfg_data[7:0];
				CFG_REQ_DIR:      cfg_q.required_direction <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	assign link.ready = can_load;
	assign accept     = link.valid && can_load;

	mfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (link.rx_byte),
		.block_last (link.block_last),
		.cfg        (cfg_q),
		.result     (result_d)
	);

	mfr_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.result_d (result_d),
		.can_load (can_load),
		.valid    (parsed.valid),
		.ready    (parsed.ready),
		.result_q (result_q)
	);

	// Drive the result channel payload
	assign parsed.byte_value   = result_q.byte_value;
	assign parsed.byte_role    = result_q.byte_role;
	assign parsed.frame_done   = result_q.frame_done;
	assign parsed.frame_status = result_q.frame_status;
	assign parsed.data_length  = result_q.data_length;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the meter frame receiver
// Streams raw link bytes (noise, clean frames, damaged frames and blocks
// cut short) into the receiver, tags every accepted byte with a local frame
// parser, and compares each tagged byte coming out against the oldest tag
// still waiting. Both channels idle at random; the result side also holds
// off for a long stretch so the receiver backs up into its link input.
// ----------------------------------------------------------------------------
module tb;
	import mfr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_BODY} parse_phase_t;
	typedef enum {FLAW_NONE, FLAW_START2, FLAW_DIR, FLAW_LEN, FLAW_SUM, FLAW_END,
		FLAW_CUT} frame_flaw_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	mfr_byte_if   link ();
	mfr_result_if parsed ();

	meter_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link),
		.parsed    (parsed),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the receiver's registers and parser state
	logic [7:0]   lim_data_len;
	logic         want_direction;
	parse_phase_t rx_phase;
	logic [8:0]   rx_pos;
	logic [8:0]   rx_left;
	logic [7:0]   rx_sum;
	logic [7:0]   rx_len;
	logic         rx_start2_ok;
	logic         rx_dir_ok;
	logic [7:0]   rx_checksum;

	result_t    pending_tags[$];
	logic [8:0] frame_q[$];

	int  cycle_count = 0;
	int  mismatch_count = 0;
	int  bytes_sent = 0;
	int  good_frames = 0;
	int  header_rejects = 0;
	int  bad_tails = 0;
	int  cfg_settings = 0;
	int  hold_req_count = 0;
	bit  link_idles_on = 1'b1;
	bit  sink_stalls_on = 1'b1;

	// Clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tags still waiting", cycle_count,
				pending_tags.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void reset_parser();
		lim_data_len   = MAX_DATA_LEN_RST;
		want_direction = REQ_DIR_RST;
		rx_phase       = HUNTING;
		rx_pos         = '0;
		rx_left        = '0;
		rx_sum         = '0;
		rx_len         = '0;
		rx_start2_ok   = 1'b0;
		rx_dir_ok      = 1'b0;
		rx_checksum    = '0;
	endfunction

	// Tag one raw byte and advance the local parser
	function automatic result_t tag_byte(input logic [7:0] b, input logic last);
		result_t    t;
		logic [8:0] pos;
		t.byte_value   = b;
		t.byte_role    = ROLE_DROPPED;
		t.frame_done   = 1'b0;
		t.frame_status = STATUS_NONE;
		t.data_length  = 8'd0;
		case (rx_phase)
			IN_HEADER: begin
				pos = rx_pos;
				rx_pos = rx_pos + 9'd1;
				rx_left = rx_left - 9'd1;
				if (pos < 9'(HEADER_BYTES)) begin
					rx_sum = rx_sum + b;
					if (pos <= 9'd6) begin
						t.byte_role = ROLE_ADDRESS;
					end else if (pos == 9'd7) begin
						t.byte_role = ROLE_START2;
						rx_start2_ok = (b == START_BYTE);
					end else if (pos == 9'd8) begin
						t.byte_role = ROLE_CONTROL;
						rx_dir_ok = (b[7] == want_direction);
					end else begin
						t.byte_role = ROLE_LENGTH;
						rx_len = b;
						t.data_length = b;
					end
				end else begin
					t.data_length = rx_len;
					if (!(rx_start2_ok && rx_dir_ok && rx_len <= lim_data_len)) begin
						t.frame_done = 1'b1;
						t.frame_status = STATUS_HDR_REJECT;
						rx_phase = HUNTING;
					end else begin
						if (rx_len == 8'd0) begin
							t.byte_role = ROLE_CHECKSUM;
							rx_checksum = b;
						end else begin
							t.byte_role = ROLE_DATA;
							t.byte_value = b - DATA_OFFSET;
							rx_sum = rx_sum + b;
						end
						rx_left = {1'b0, rx_len} + 9'd1;
						rx_phase = IN_BODY;
					end
				end
			end
			IN_BODY: begin
				t.data_length = rx_len;
				rx_pos = rx_pos + 9'd1;
				if (rx_left <= 9'd1) begin
					t.byte_role = ROLE_END;
					t.frame_done = 1'b1;
					t.frame_status = (b == END_BYTE && rx_checksum == rx_sum) ?
						STATUS_GOOD : STATUS_BAD_TAIL;
					rx_left = '0;
					rx_phase = HUNTING;
				end else begin
					rx_left = rx_left - 9'd1;
					if (rx_left == 9'd1) begin
						t.byte_role = ROLE_CHECKSUM;
						rx_checksum = b;
					end else begin
						t.byte_role = ROLE_DATA;
						t.byte_value = b - DATA_OFFSET;
						rx_sum = rx_sum + b;
					end
				end
			end
			default: begin
				rx_phase = HUNTING;
				if (b == START_BYTE) begin
					t.byte_role  = ROLE_START;
					rx_sum       = START_BYTE;
					rx_pos       = 9'd1;
					rx_left      = 9'(HEADER_BYTES);
					rx_len       = '0;
					rx_start2_ok = 1'b0;
					rx_dir_ok    = 1'b0;
					rx_checksum  = '0;
					rx_phase     = IN_HEADER;
				end
			end
		endcase
		// block end drops whatever frame is open
		if (last)
			rx_phase = HUNTING;
		return t;
	endfunction

	// Lay out one frame in frame_q as {block_last, byte}
	function automatic void build_frame(input int len, input frame_flaw_t flaw);
		logic [7:0] b;
		logic [7:0] sum;
		int         cut;
		frame_q.delete();
		frame_q.push_back({1'b0, START_BYTE});
		repeat (6) frame_q.push_back({1'b0, 8'($urandom_range(0, 255))});
		b = START_BYTE;
		if (flaw == FLAW_START2) begin
			do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
		end
		frame_q.push_back({1'b0, b});
		b = 8'($urandom_range(0, 255));
		b[7] = (flaw == FLAW_DIR) ? ~want_direction : want_direction;
		frame_q.push_back({1'b0, b});
		frame_q.push_back({1'b0, 8'(len)});
		repeat (len) frame_q.push_back({1'b0, 8'($urandom_range(0, 255))});
		sum = 8'd0;
		foreach (frame_q[i]) sum = sum + frame_q[i][7:0];
		if (flaw == FLAW_SUM)
			sum = sum + 8'($urandom_range(1, 255));
		frame_q.push_back({1'b0, sum});
		b = END_BYTE;
		if (flaw == FLAW_END) begin
			do b = 8'($urandom_range(0, 255)); while (b == END_BYTE);
		end
		frame_q.push_back({1'b0, b});
		// a rejected header ends the frame on its eleventh byte
		if (flaw == FLAW_START2 || flaw == FLAW_DIR || flaw == FLAW_LEN) begin
			while (frame_q.size() > 11) void'(frame_q.pop_back());
		end
		if (flaw == FLAW_CUT) begin
			cut = $urandom_range(0, frame_q.size() - 2);
			frame_q[cut][8] = 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			frame_q[frame_q.size() - 1][8] = 1'b1;
		end
	endfunction

	// Offer one byte, wait for its transfer, then queue its tag
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (link_idles_on && $urandom_range(0, 99) < 6) begin
			gap = $urandom_range(1, 5);
			link.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		link.valid      <= 1'b1;
		link.rx_byte    <= b;
		link.block_last <= last;
		@(posedge clk);
		while (link.ready !== 1'b1) @(posedge clk);
		pending_tags.push_back(tag_byte(b, last));
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) send_byte(frame_q[i][7:0], frame_q[i][8]);
	endtask

	// Noise burst, clean frame or damaged frame, mostly short
	task automatic send_random_frame();
		int          pick;
		int          len;
		int          cap;
		frame_flaw_t flaw;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			return;
		end
		cap = (lim_data_len < 8) ? int'(lim_data_len) : 8;
		if ($urandom_range(0, 19) == 0)
			len = $urandom_range(0, int'(lim_data_len));
		else
			len = $urandom_range(0, cap);
		flaw = FLAW_NONE;
		if (pick >= 70)
			flaw = frame_flaw_t'($urandom_range(int'(FLAW_START2), int'(FLAW_CUT)));
		if (flaw == FLAW_LEN) begin
			if (lim_data_len == 8'hFF)
				flaw = FLAW_DIR;
			else
				len = $urandom_range(int'(lim_data_len) + 1, 255);
		end
		build_frame(len, flaw);
		send_frame();
	endtask

	task automatic run_frames(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) send_random_frame();
	endtask

	// Drop valid and wait until every tag has come back
	task automatic settle();
		link.valid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Present one register write for a single edge; the caller drops the enable
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == CFG_MAX_DATA_LEN)
			lim_data_len = value;
		else
			want_direction = value[0];
	endtask

	task automatic set_limits(input logic [7:0] max_len, input logic dir);
		write_reg(CFG_MAX_DATA_LEN, max_len);
		write_reg(CFG_REQ_DIR, {7'd0, dir});
		cfg_wr_en <= 1'b0;
		cfg_settings++;
	endtask

	// Compare one transferred result against the oldest waiting tag
	task automatic check_result();
		result_t got;
		result_t want;
		got.byte_value   = parsed.byte_value;
		got.byte_role    = parsed.byte_role;
		got.frame_done   = parsed.frame_done;
		got.frame_status = parsed.frame_status;
		got.data_length  = parsed.data_length;
		if (pending_tags.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: result with no byte waiting: value %02h role %0d", $realtime,
					got.byte_value, got.byte_role);
			return;
		end
		want = pending_tags.pop_front();
		if (got.byte_value !== want.byte_value || got.byte_role !== want.byte_role ||
				got.frame_done !== want.frame_done ||
				got.frame_status !== want.frame_status ||
				got.data_length !== want.data_length) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS) begin
				$display("%0t: mismatch: expected value %02h role %0d done %0b status %0d len %0d",
					$realtime, want.byte_value, want.byte_role, want.frame_done,
					want.frame_status, want.data_length);
				$display("%0t:           got value %02h role %0d done %0b status %0d len %0d",
					$realtime, got.byte_value, got.byte_role, got.frame_done,
					got.frame_status, got.data_length);
			end
		end else if (want.frame_done) begin
			case (want.frame_status)
				STATUS_GOOD:       good_frames++;
				STATUS_HDR_REJECT: header_rejects++;
				default:           bad_tails++;
			endcase
		end
	endtask

	// Result side: check each transfer, stall at random, hold off on request
	initial begin : result_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		parsed.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && parsed.valid === 1'b1 && parsed.ready === 1'b1)
				check_result();
			if (hold_seen != hold_req_count) begin
				hold_seen = hold_req_count;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				parsed.ready <= 1'b0;
			end else if (sink_stalls_on && $urandom_range(0, 99) < 6) begin
				parsed.ready <= 1'b0;
			end else begin
				parsed.ready <= 1'b1;
			end
		end
	end

	// Noise, one clean empty frame, one header rejected on direction
	task automatic test_directed();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		build_frame(0, FLAW_NONE);
		send_frame();
		build_frame(1, FLAW_DIR);
		send_frame();
		settle();
	endtask

	task automatic test_random_frames();
		run_frames(150);
		settle();
	endtask

	// Walk the length limit and direction through their extremes, a random pair and the reset values
	task automatic test_config_extremes();
		set_limits(8'd0, 1'b0);
		run_frames(60);
		settle();
		set_limits(8'hFF, 1'b1);
		build_frame(255, FLAW_NONE);
		send_frame();
		run_frames(60);
		settle();
		set_limits(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		run_frames(80);
		settle();
		set_limits(MAX_DATA_LEN_RST, REQ_DIR_RST);
	endtask

	// Hold the result side off so the receiver backs up into the link
	task automatic test_back_pressure();
		hold_req_count <= hold_req_count + 1;
		run_frames(60);
		settle();
	endtask

	task automatic test_steady_stream();
		link_idles_on  <= 1'b0;
		sink_stalls_on <= 1'b0;
		run_frames(160);
		settle();
		link_idles_on  <= 1'b1;
		sink_stalls_on <= 1'b1;
	endtask

	initial begin
		link.valid      <= 1'b0;
		link.rx_byte    <= 8'd0;
		link.block_last <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_index       <= CFG_MAX_DATA_LEN;
		cfg_data        <= 8'd0;
		arst_n          <= 1'b0;
		reset_parser();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_config_extremes();
		test_back_pressure();
		test_steady_stream();
		settle();

		$display("Streamed %0d link bytes over %0d limit settings plus reset values.",
			bytes_sent, cfg_settings);
		$display("Frames closed: %0d good, %0d header rejected, %0d bad checksum or end.",
			good_frames, header_rejects, bad_tails);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
